>>> sv/lwqd_pkg.sv
// Shared constants, types and command/status bundles for the least-work queue dispatcher.
package lwqd_pkg;

    localparam int NUM_SERVERS = 8;
    localparam int QUEUE_DEPTH = 64;
    localparam int SRV_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = HEAD_W + 1;
    localparam int STORE_DEPTH = NUM_SERVERS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int STAMP_W     = 32;
    localparam int DRAW_W      = 16;
    localparam int ACT_W       = 4;
    localparam int COST_W      = LEN_W + DRAW_W + 1;
    localparam int WAIT_W      = 48;
    localparam int WAITING_W   = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SERVERS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVICE_TIME = 1'd1;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(NUM_SERVERS);
    localparam logic [DRAW_W-1:0] MAXT_RESET   = DRAW_W'(1);

    typedef logic [DRAW_W-1:0] draw_t;

    typedef struct packed {
        logic load;      // latch request, clear per-tick results
        logic scan;      // evaluate cost of queue k
        logic push;      // enqueue arrival on chosen queue
        logic read;      // issue store read for server k
        logic skip;      // server k without dequeue: count down, advance
        logic commit;    // finish dequeue of server k
        logic finish;    // load output register, bump tick
    } cmd_t;

    typedef struct packed {
        logic arrival;
        logic last_k;
        logic need_job;
        logic out_free;
    } status_t;

endpackage

>>> sv/lwqd_if.sv
// Request and result channel interfaces.
interface lwqd_in_if;
    logic                 valid;
    logic                 ready;
    logic                 arrival;
    lwqd_pkg::draw_t      draw_0;
    lwqd_pkg::draw_t      draw_1;
    lwqd_pkg::draw_t      draw_2;
    lwqd_pkg::draw_t      draw_3;
    lwqd_pkg::draw_t      draw_4;
    lwqd_pkg::draw_t      draw_5;
    lwqd_pkg::draw_t      draw_6;
    lwqd_pkg::draw_t      draw_7;
    modport source (output valid, arrival, draw_0, draw_1, draw_2, draw_3, draw_4, draw_5,
                     draw_6, draw_7, input ready);
    modport sink   (input valid, arrival, draw_0, draw_1, draw_2, draw_3, draw_4, draw_5,
                     draw_6, draw_7, output ready);
endinterface

interface lwqd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  chosen_queue;
    logic        arrival_dropped;
    logic [3:0]  started_now;
    logic [31:0] served_total;
    logic [47:0] wait_total;
    logic [9:0]  waiting_total;
    logic [31:0] tick_now;
    modport source (output valid, chosen_queue, arrival_dropped, started_now, served_total,
                     wait_total, waiting_total, tick_now, input ready);
    modport sink   (input valid, chosen_queue, arrival_dropped, started_now, served_total,
                     wait_total, waiting_total, tick_now, output ready);
endinterface

>>> sv/least_work_queue_dispatcher_top.sv
// Top level of the least-work queue dispatcher: channels, sequencer and datapath.
// One request is one tick: an arrival flag and a service draw per server. On an
// arrival the tick stamp joins the active queue of least cost (length times half
// the maximum service time, plus remaining service; lowest index wins a tie); a
// full queue drops it and flags it. Then each active server in index order either
// dequeues a waiting job (wait added to a saturating sum, draw clamped to 1..max
// loaded) or counts down. One result per request. Steps of a request: one accept
// step; with an arrival, a cost scan of the active queues, one queue per cycle,
// and one push step; one skip step per server that only counts down and a read
// and a commit step per server that dequeues (the job stamp store has one
// registered read port); and one step to load the result register. With no
// arrival the scan state passes straight to the service pass, with no push.
// The next request is taken once the previous one has gone to the result
// register, which holds it until the sink takes it; a result still waiting there
// stalls the result load. No clearing pass after reset: the stamp store is only
// read at written entries. Configuration must be written only while idle; the
// block itself does not enforce it.
module least_work_queue_dispatcher_top (
    input  logic                                clk,
    input  logic                                rst_n,
    lwqd_in_if.sink                             in_ch,
    lwqd_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [lwqd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lwqd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lwqd_pkg::cmd_t    cmd;
    lwqd_pkg::status_t status;
    lwqd_pkg::draw_t   draws [lwqd_pkg::NUM_SERVERS];

    assign draws[0] = in_ch.draw_0;
    assign draws[1] = in_ch.draw_1;
    assign draws[2] = in_ch.draw_2;
    assign draws[3] = in_ch.draw_3;
    assign draws[4] = in_ch.draw_4;
    assign draws[5] = in_ch.draw_5;
    assign draws[6] = in_ch.draw_6;
    assign draws[7] = in_ch.draw_7;

    // sequencer: owns request ready
    lwqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: queue state, stamp store, statistics, result register
    lwqd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .arrival         (in_ch.arrival),
        .draw_in         (draws),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .chosen_queue    (out_ch.chosen_queue),
        .arrival_dropped (out_ch.arrival_dropped),
        .started_now     (out_ch.started_now),
        .served_total    (out_ch.served_total),
        .wait_total      (out_ch.wait_total),
        .waiting_total   (out_ch.waiting_total),
        .tick_now        (out_ch.tick_now)
    );

    // a taken request leaves the input closed in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request accepted while previous tick still in work");

    // queued jobs never exceed total store capacity
    a_waiting_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.waiting_total <= 10'(lwqd_pkg::STORE_DEPTH)))
        else $error("waiting count beyond store capacity");

    // at most one start per server per tick
    a_started_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.started_now <= 4'(lwqd_pkg::NUM_SERVERS)))
        else $error("more starts than servers");

    // each sequencer state issues at most one datapath step per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan, cmd.push, cmd.read, cmd.skip, cmd.commit, cmd.finish}))
        else $error("sequencer issued overlapping commands");

endmodule

>>> sv/lwqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lwqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/lwqd_ctrl.sv
// Sequencer for one tick: cost scan, enqueue, per-server service pass, result load.
module lwqd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lwqd_pkg::status_t status,
    output lwqd_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_SERV = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.arrival)
                begin
                    state_next = ST_SERV;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (status.last_k)
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_SERV;
            end
            ST_SERV:
            begin
                if (status.need_job)
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    cmd.skip = 1'b1;
                    if (status.last_k)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WAIT:
            begin
                cmd.commit = 1'b1;
                state_next = status.last_k ? ST_DONE : ST_SERV;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/lwqd_dp.sv
// Queue, server and statistics datapath with the job stamp store and result register.
module lwqd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lwqd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lwqd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                arrival,
    input  lwqd_pkg::draw_t                     draw_in [lwqd_pkg::NUM_SERVERS],
    input  lwqd_pkg::cmd_t                      cmd,
    output lwqd_pkg::status_t                   status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          chosen_queue,
    output logic                                arrival_dropped,
    output logic [3:0]                          started_now,
    output logic [31:0]                         served_total,
    output logic [lwqd_pkg::WAIT_W-1:0]         wait_total,
    output logic [lwqd_pkg::WAITING_W-1:0]      waiting_total,
    output logic [31:0]                         tick_now
);

    localparam int NS = lwqd_pkg::NUM_SERVERS;

    // configuration
    logic [lwqd_pkg::ACT_W-1:0]  active_reg;
    logic [lwqd_pkg::DRAW_W-1:0] maxt_reg;

    // queue and server state
    logic [lwqd_pkg::LEN_W-1:0]  len_reg  [NS];
    logic [lwqd_pkg::HEAD_W-1:0] head_reg [NS];
    logic [lwqd_pkg::DRAW_W-1:0] svc_reg  [NS];

    logic [31:0]                     tick_reg;
    logic [31:0]                     served_reg;
    logic [lwqd_pkg::WAIT_W-1:0]     wsum_reg;
    logic [lwqd_pkg::WAITING_W-1:0]  waiting_reg;

    // per-tick working state
    logic [lwqd_pkg::SRV_W-1:0]  k_reg;
    logic                        arr_reg;
    logic [lwqd_pkg::SRV_W-1:0]  chosen_reg;
    logic                        dropped_reg;
    logic [3:0]                  started_reg;
    logic [lwqd_pkg::COST_W-1:0] best_reg;
    lwqd_pkg::draw_t             draw_reg [NS];
    logic                        out_valid_reg;

    logic [lwqd_pkg::SRV_W-1:0]  last_idx;
    logic [lwqd_pkg::DRAW_W-1:0] maxt;
    logic [lwqd_pkg::DRAW_W-2:0] weight;
    logic [lwqd_pkg::COST_W-1:0] cost;
    logic [lwqd_pkg::DRAW_W-1:0] draw_k;
    logic [lwqd_pkg::DRAW_W-1:0] draw_clamped;
    logic [31:0]                 wait_k;
    logic [lwqd_pkg::WAIT_W:0]   wsum_ext;
    logic [lwqd_pkg::HEAD_W-1:0] tail;
    logic                        full;
    logic                        ram_we;
    logic [lwqd_pkg::ADDR_W-1:0] ram_waddr;
    logic [lwqd_pkg::ADDR_W-1:0] ram_raddr;
    logic [31:0]                 ram_rdata;

    always_comb
    begin
        if (active_reg == '0)
        begin
            last_idx = '0;
        end
        else if (active_reg > lwqd_pkg::ACT_W'(NS))
        begin
            last_idx = lwqd_pkg::SRV_W'(NS - 1);
        end
        else
        begin
            last_idx = lwqd_pkg::SRV_W'(active_reg - 1'b1);
        end
    end

    assign maxt   = (maxt_reg == '0) ? lwqd_pkg::DRAW_W'(1) : maxt_reg;
    assign weight = maxt[lwqd_pkg::DRAW_W-1:1];
    assign cost   = lwqd_pkg::COST_W'(len_reg[k_reg]) * lwqd_pkg::COST_W'(weight)
                  + lwqd_pkg::COST_W'(svc_reg[k_reg]);

    assign draw_k       = draw_reg[k_reg];
    assign draw_clamped = (draw_k == '0) ? lwqd_pkg::DRAW_W'(1)
                        : ((draw_k > maxt) ? maxt : draw_k);

    assign wait_k   = tick_reg - ram_rdata;
    assign wsum_ext = {1'b0, wsum_reg} + (lwqd_pkg::WAIT_W + 1)'(wait_k);

    // ring position: head + length modulo depth
    assign tail = head_reg[chosen_reg] + len_reg[chosen_reg][lwqd_pkg::HEAD_W-1:0];
    assign full = (len_reg[chosen_reg] >= lwqd_pkg::LEN_W'(lwqd_pkg::QUEUE_DEPTH));

    assign ram_we    = cmd.push && arr_reg && !full;
    assign ram_waddr = lwqd_pkg::ADDR_W'(chosen_reg) * lwqd_pkg::ADDR_W'(lwqd_pkg::QUEUE_DEPTH)
                     + lwqd_pkg::ADDR_W'(tail);
    assign ram_raddr = lwqd_pkg::ADDR_W'(k_reg) * lwqd_pkg::ADDR_W'(lwqd_pkg::QUEUE_DEPTH)
                     + lwqd_pkg::ADDR_W'(head_reg[k_reg]);

    lwqd_ram #(
        .WIDTH (lwqd_pkg::STAMP_W),
        .DEPTH (lwqd_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tick_reg),
        .re    (cmd.read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.arrival  = arr_reg;
    assign status.last_k   = (k_reg == last_idx);
    assign status.need_job = (svc_reg[k_reg] == '0) && (len_reg[k_reg] != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= lwqd_pkg::ACTIVE_RESET;
            maxt_reg      <= lwqd_pkg::MAXT_RESET;
            len_reg       <= '{default: '0};
            head_reg      <= '{default: '0};
            svc_reg       <= '{default: '0};
            tick_reg      <= '0;
            served_reg    <= '0;
            wsum_reg      <= '0;
            waiting_reg   <= '0;
            k_reg         <= '0;
            arr_reg       <= 1'b0;
            chosen_reg    <= '0;
            dropped_reg   <= 1'b0;
            started_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lwqd_pkg::CFG_ACTIVE_SERVERS:
                        active_reg <= cfg_data[lwqd_pkg::ACT_W-1:0];
                    lwqd_pkg::CFG_MAX_SERVICE_TIME:
                        maxt_reg <= cfg_data[lwqd_pkg::DRAW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.load)
            begin
                arr_reg     <= arrival;
                k_reg       <= '0;
                chosen_reg  <= '0;
                dropped_reg <= 1'b0;
                started_reg <= '0;
            end

            if (cmd.scan)
            begin
                if ((k_reg == '0) || (cost < best_reg))
                begin
                    chosen_reg <= k_reg;
                end
                k_reg <= status.last_k ? '0 : k_reg + 1'b1;
            end

            if (cmd.push && arr_reg)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    len_reg[chosen_reg] <= len_reg[chosen_reg] + 1'b1;
                    waiting_reg         <= waiting_reg + 1'b1;
                end
            end

            if (cmd.skip)
            begin
                if (svc_reg[k_reg] != '0)
                begin
                    svc_reg[k_reg] <= svc_reg[k_reg] - 1'b1;
                end
                k_reg <= k_reg + 1'b1;
            end

            if (cmd.commit)
            begin
                head_reg[k_reg] <= head_reg[k_reg] + 1'b1;
                len_reg[k_reg]  <= len_reg[k_reg] - 1'b1;
                waiting_reg     <= waiting_reg - 1'b1;
                svc_reg[k_reg]  <= draw_clamped;
                served_reg      <= served_reg + 1'b1;
                started_reg     <= started_reg + 1'b1;
                wsum_reg        <= wsum_ext[lwqd_pkg::WAIT_W] ? '1
                                 : wsum_ext[lwqd_pkg::WAIT_W-1:0];
                k_reg           <= k_reg + 1'b1;
            end

            if (cmd.finish)
            begin
                tick_reg      <= tick_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            draw_reg <= draw_in;
        end
        if (cmd.scan && ((k_reg == '0) || (cost < best_reg)))
        begin
            best_reg <= cost;
        end
        if (cmd.finish)
        begin
            chosen_queue    <= 3'(chosen_reg);
            arrival_dropped <= dropped_reg;
            started_now     <= started_reg;
            served_total    <= served_reg;
            wait_total      <= wsum_reg;
            waiting_total   <= waiting_reg;
            tick_now        <= tick_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
